@@ rtl/core/bounded_set_store_defines.svh @@
// Assertion macros used by the port-level checker file of the bounded set store.
`ifndef BOUNDED_SET_STORE_DEFINES_SVH
`define BOUNDED_SET_STORE_DEFINES_SVH

// Property checked on every rising edge while reset is released.
`define BSS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Property checked on every rising edge, reset included.
`define BSS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/bss_pkg.sv @@
// Package of the bounded set store: beat types, request and status codes, defaults.
`timescale 1ns / 1ps

package bss_pkg;

    // Default sizes of the store.
    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // Request codes; the unused code behaves as a query.
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // Result status codes.
    localparam logic [2:0] STATUS_DONE     = 3'd0;
    localparam logic [2:0] STATUS_DUP      = 3'd1;
    localparam logic [2:0] STATUS_FULL     = 3'd2;
    localparam logic [2:0] STATUS_NOTFOUND = 3'd3;
    localparam logic [2:0] STATUS_EMPTY    = 3'd4;

    // One request beat.
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] value;
    } bss_req_t;

    // One result beat.
    typedef struct packed {
        logic [2:0] status;
        logic       found;
        logic [3:0] location;
        logic [4:0] cardinality;
    } bss_rsp_t;

endpackage

@@ rtl/core/bss_mem.sv @@
// Element memory of the bounded set store: one write port, one registered read port.
`timescale 1ns / 1ps

module bss_mem #(
    parameter int DEPTH = bss_pkg::CAPACITY_DEF,
    parameter int WIDTH = bss_pkg::VALUE_WIDTH_DEF,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    import bss_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with the data registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/bss_seq.sv @@
// Sequencer of the bounded set store: scan, update and shift over the element memory.
`timescale 1ns / 1ps

module bss_seq #(
    parameter int CAPACITY    = bss_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = bss_pkg::VALUE_WIDTH_DEF,
    parameter int AW          = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  bss_pkg::bss_req_t      req,
    output logic                   res_valid,
    input  logic                   res_ready,
    output bss_pkg::bss_rsp_t      res,
    output logic                   mem_wr_en,
    output logic [AW-1:0]          mem_wr_addr,
    output logic [VALUE_WIDTH-1:0] mem_wr_data,
    output logic                   mem_rd_en,
    output logic [AW-1:0]          mem_rd_addr,
    input  logic [VALUE_WIDTH-1:0] mem_rd_data
);
    import bss_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 4;
    localparam int NW = CW + 5;

    localparam logic [2:0] SEQ_IDLE  = 3'd0;
    localparam logic [2:0] SEQ_SCAN  = 3'd1;
    localparam logic [2:0] SEQ_APPLY = 3'd2;
    localparam logic [2:0] SEQ_SHIFT = 3'd3;
    localparam logic [2:0] SEQ_DONE  = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   pend_reg, pend_next;
    logic [1:0]             mode_reg, mode_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [AW-1:0]          ptr_reg, ptr_next;
    logic                   hit_reg, hit_next;
    logic [AW-1:0]          where_reg, where_next;
    logic [2:0]             status_reg, status_next;

    logic [VALUE_WIDTH+31:0] val_wide;
    logic [VALUE_WIDTH-1:0]  val_in;
    logic [CW-1:0]           idx_plus1;
    logic                    idx_live;
    logic                    match;
    logic [LW-1:0]           loc_wide;
    logic [NW-1:0]           card_wide;

    // Only the low VALUE_WIDTH bits of a request value are kept.
    assign val_wide  = {{VALUE_WIDTH{1'b0}}, req.value};
    assign val_in    = val_wide[VALUE_WIDTH-1:0];

    // The shared compare unit: entry against key, index against fill level.
    assign match     = pend_reg && (mem_rd_data == val_reg);
    assign idx_live  = idx_reg < count_reg;
    assign idx_plus1 = CW'(idx_reg + 1'b1);

    // Result beat, fields masked to their port widths.
    assign loc_wide  = LW'(where_reg);
    assign card_wide = NW'(count_reg);
    assign res.status      = status_reg;
    assign res.found       = hit_reg;
    assign res.location    = loc_wide[3:0];
    assign res.cardinality = card_wide[4:0];

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pend_next   = pend_reg;
        mode_next   = mode_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        ptr_next    = ptr_reg;
        hit_next    = hit_reg;
        where_next  = where_reg;
        status_next = status_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = ptr_reg;
        mem_wr_data = mem_rd_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg[AW-1:0];
        req_ready   = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    mode_next  = req.mode;
                    val_next   = val_in;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    hit_next   = 1'b0;
                    where_next = '0;
                    state_next = SEQ_SCAN;
                end
            end

            // Walk the live entries; the read issued last cycle is compared now.
            SEQ_SCAN:
            begin
                if (match)
                begin
                    hit_next   = 1'b1;
                    where_next = ptr_reg;
                    pend_next  = 1'b0;
                    state_next = SEQ_APPLY;
                end
                else if (idx_live)
                begin
                    mem_rd_en = 1'b1;
                    ptr_next  = idx_reg[AW-1:0];
                    idx_next  = idx_plus1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = SEQ_APPLY;
                end
            end

            // Decide the outcome; an insert writes its single entry here, a remove that hits goes on to the shift.
            SEQ_APPLY:
            begin
                state_next = SEQ_DONE;
                case (mode_reg)
                    MODE_INSERT:
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = STATUS_FULL;
                        end
                        else if (hit_reg)
                        begin
                            status_next = STATUS_DUP;
                        end
                        else
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = count_reg[AW-1:0];
                            mem_wr_data = val_reg;
                            count_next  = CW'(count_reg + 1'b1);
                            status_next = STATUS_DONE;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else if (!hit_reg)
                        begin
                            status_next = STATUS_NOTFOUND;
                        end
                        else
                        begin
                            count_next  = CW'(count_reg - 1'b1);
                            status_next = STATUS_DONE;
                            idx_next    = CW'(where_reg);
                            pend_next   = 1'b0;
                            state_next  = SEQ_SHIFT;
                        end
                    end
                    default:
                    begin
                        status_next = hit_reg ? STATUS_DONE : STATUS_NOTFOUND;
                    end
                endcase
            end

            // Close the gap: read entry i+1, and write it to entry i in the next cycle.
            SEQ_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_wr_en = 1'b1;
                end
                if (idx_live)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_plus1[AW-1:0];
                    ptr_next    = idx_reg[AW-1:0];
                    idx_next    = idx_plus1;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = SEQ_DONE;
                end
            end

            SEQ_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = SEQ_IDLE;
                end
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        ptr_reg    <= ptr_next;
        hit_reg    <= hit_next;
        where_reg  <= where_next;
        status_reg <= status_next;
    end

endmodule

@@ rtl/core/bounded_set_store.sv @@
// Top level of the bounded set store: sequencer, element memory and result register.
`timescale 1ns / 1ps

// A duplicate-free list of up to CAPACITY values kept in insertion order.
// Request channel (req_valid, req_stall, req): one beat carries a mode
// (insert, remove, query) and a value; a beat is taken when req_valid is
// high and req_stall is low. The block works on one request at a time and
// holds req_stall high from acceptance until its result has left the
// sequencer.
// Result channel (rsp_valid, rsp_stall, rsp): exactly one beat per request,
// held in an output register while rsp_stall is high, so the next request
// may be accepted while a result still waits.
// With n stored entries, a request scans up to n entries before its
// result is decided; a remove that hits also closes the gap by shifting
// the later entries. A new request is taken in the cycle after the result
// leaves the sequencer. The scan and the shift are paced by the single
// read port of the element memory, which delivers one entry per cycle to
// each of them.
// Reset clears the element count and both valid flags; no memory clearing
// pass is needed, as only entries below the count are ever read.

module bounded_set_store #(
    parameter int CAPACITY    = bss_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = bss_pkg::VALUE_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  bss_pkg::bss_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output bss_pkg::bss_rsp_t rsp
);
    import bss_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                   seq_ready;
    logic                   res_valid;
    logic                   res_ready;
    bss_rsp_t               res;
    logic                   mem_wr_en;
    logic [AW-1:0]          mem_wr_addr;
    logic [VALUE_WIDTH-1:0] mem_wr_data;
    logic                   mem_rd_en;
    logic [AW-1:0]          mem_rd_addr;
    logic [VALUE_WIDTH-1:0] mem_rd_data;

    logic     rsp_valid_reg, rsp_valid_next;
    bss_rsp_t rsp_reg;

    assign req_stall = !seq_ready;

    bss_seq #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (seq_ready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    bss_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // The output register takes a new beat when empty or being drained.
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload, loaded only on a handover from the sequencer.
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/core/bss_checker.sv @@
// Port-level checker of the bounded set store and its bind to the top level.
`timescale 1ns / 1ps
`include "bounded_set_store_defines.svh"

module bss_checker #(
    parameter int CAPACITY = bss_pkg::CAPACITY_DEF
) (
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input bss_pkg::bss_rsp_t rsp
);
    import bss_pkg::*;

    // A stalled result beat stays in place.
    `BSS_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "result beat changed while stalled")

    // Reset leaves no result on the channel.
    `BSS_ASSERT_ALWAYS(a_rsp_reset, clk, !rst_n |=> !rsp_valid, "result valid after reset")

    // The count never exceeds the capacity.
    `BSS_ASSERT(a_card_bound, clk, rst_n, rsp_valid |-> rsp.cardinality <= CAPACITY, "cardinality above capacity")

    // A remove from an empty store finds nothing and leaves it empty.
    `BSS_ASSERT(a_empty_reject, clk, rst_n, rsp_valid && rsp.status == STATUS_EMPTY |-> rsp.cardinality == 5'd0 && !rsp.found, "empty reject with entries")

    // A miss reports no hit and location zero.
    `BSS_ASSERT(a_miss_clean, clk, rst_n, rsp_valid && rsp.status == STATUS_NOTFOUND |-> !rsp.found && rsp.location == 4'd0, "not-found result with a hit or location")

endmodule

bind bounded_set_store bss_checker #(
    .CAPACITY (CAPACITY)
) u_bss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

@@ dv/bss_result_checker.sv @@
// Checker of the bounded set store: mirrors the set, predicts every result beat and compares.
`timescale 1ns / 1ps

module bss_result_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_stall,
    input  bss_pkg::bss_req_t req,
    input  logic              rsp_valid,
    input  logic              rsp_stall,
    input  bss_pkg::bss_rsp_t rsp,
    output int                mismatch_count,
    output int                pending_results
);
    import bss_pkg::*;

    // Mirror of the stored elements and of the element count.
    logic [31:0] members [CAPACITY_DEF];
    int          member_total;
    int          failures;
    bss_rsp_t    expected_results [$];

    // Work out the result of one request and apply it to the mirrored set.
    function automatic bss_rsp_t apply_set_request(input bss_req_t beat);
        bss_rsp_t outcome;
        logic     hit;
        int       where;
        hit   = 1'b0;
        where = 0;
        for (int i = 0; i < member_total; i++)
        begin
            if (!hit && members[i] == beat.value)
            begin
                hit   = 1'b1;
                where = i;
            end
        end
        case (beat.mode)
            MODE_INSERT:
            begin
                if (member_total >= CAPACITY_DEF)
                    outcome.status = STATUS_FULL;
                else if (hit)
                    outcome.status = STATUS_DUP;
                else
                begin
                    members[member_total] = beat.value;
                    member_total++;
                    outcome.status = STATUS_DONE;
                end
            end
            MODE_REMOVE:
            begin
                if (member_total == 0)
                    outcome.status = STATUS_EMPTY;
                else if (!hit)
                    outcome.status = STATUS_NOTFOUND;
                else
                begin
                    // Close the gap by moving every later entry one place forward.
                    for (int i = where; i + 1 < member_total; i++)
                        members[i] = members[i + 1];
                    member_total--;
                    outcome.status = STATUS_DONE;
                end
            end
            // Queries, and the spare code, which behaves as a query.
            default:
                outcome.status = hit ? STATUS_DONE : STATUS_NOTFOUND;
        endcase
        outcome.found       = hit;
        outcome.location    = where[3:0];
        outcome.cardinality = member_total[4:0];
        return outcome;
    endfunction

    // Compare each result beat with the oldest prediction, then record any new request.
    always @(posedge clk or negedge rst_n)
    begin
        bss_rsp_t wanted;
        if (!rst_n)
        begin
            member_total = 0;
            failures     = 0;
            expected_results.delete();
            mismatch_count  <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    if (failures < 10)
                        $display("%0t: unexpected result beat: status %0d found %0d loc %0d card %0d",
                                 $realtime, rsp.status, rsp.found, rsp.location, rsp.cardinality);
                    failures++;
                end
                else
                begin
                    wanted = expected_results.pop_front();
                    if (rsp.status !== wanted.status || rsp.found !== wanted.found ||
                        rsp.location !== wanted.location ||
                        rsp.cardinality !== wanted.cardinality)
                    begin
                        if (failures < 10)
                        begin
                            $display("%0t: result mismatch, expected status %0d found %0d loc %0d card %0d",
                                     $realtime, wanted.status, wanted.found, wanted.location,
                                     wanted.cardinality);
                            $display("%0t:                  actual status %0d found %0d loc %0d card %0d",
                                     $realtime, rsp.status, rsp.found, rsp.location,
                                     rsp.cardinality);
                        end
                        failures++;
                    end
                end
            end
            if (req_valid && !req_stall)
                expected_results.push_back(apply_set_request(req));
            pending_results <= expected_results.size();
            mismatch_count  <= failures;
        end
    end

endmodule

@@ dv/tb_bounded_set_store.sv @@
// Testbench top of the bounded set store: clock, reset, request stimulus, result stalls, verdict.
`timescale 1ns / 1ps

module tb_bounded_set_store;
    import bss_pkg::*;

    // The spare request code, which the block treats as a query.
    localparam logic [1:0] MODE_SPARE   = 2'd3;
    localparam int         RANDOM_ITEMS = 650;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    bss_req_t req;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    bss_rsp_t rsp;
    int       mismatch_count;
    int       pending_results;
    int       cycle_count;
    bit       sender_steady = 1'b0;

    bounded_set_store DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    bss_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .rsp             (rsp),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always #5 clk = ~clk;

    // Result side: random stalls with a chance of about 18 in a hundred, never inside the quiet window.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall   <= 1'b0;
            cycle_count <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count >= 4000 && cycle_count < 7000)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(0, 99) < 18);
        end
    end

    // Present one request beat, after a random idle gap unless the sender is steady, and hold it until it is taken.
    task automatic send_request(input logic [1:0] op, input logic [31:0] operand);
        bss_req_t beat;
        beat.mode  = op;
        beat.value = operand;
        while (!sender_steady && $urandom_range(0, 99) < 18)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Stop sending and wait until every predicted result beat has come back.
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] value_pool [24];
        int          pool_size;
        int          phase_len;
        int          insert_weight;
        int          remove_weight;
        int          pick;
        int          sent;
        logic [1:0]  op;
        logic [31:0] operand;
        req_valid <= 1'b0;
        req       <= '0;
        rst_n     <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty store, field extremes, duplicates and the spare code.
        send_request(MODE_QUERY,  32'h0000_0001);
        send_request(MODE_REMOVE, 32'h0000_0001);
        send_request(MODE_INSERT, 32'h0000_0000);
        send_request(MODE_INSERT, 32'hFFFF_FFFF);
        send_request(MODE_INSERT, 32'h0000_0000);
        send_request(MODE_QUERY,  32'hFFFF_FFFF);
        send_request(MODE_SPARE,  32'h0000_0000);
        send_request(MODE_REMOVE, 32'h1234_5678);
        send_request(MODE_REMOVE, 32'h0000_0000);

        // Fill the store, then insert into a full store with a present and an absent value.
        for (int i = 1; i < CAPACITY_DEF; i++)
            send_request(MODE_INSERT, 32'h8000_0000 + i);
        send_request(MODE_INSERT, 32'hFFFF_FFFF);
        send_request(MODE_INSERT, 32'h7FFF_FFFF);
        send_request(MODE_QUERY,  32'h8000_000F);
        send_request(MODE_REMOVE, 32'h8000_000F);
        send_request(MODE_REMOVE, 32'hFFFF_FFFF);
        drain_results();

        // Random phases over a slowly changing pool of values, so that hits are common.
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 24; i++)
            value_pool[i] = $urandom();
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            for (int i = $urandom_range(0, 6); i > 0; i--)
                value_pool[$urandom_range(0, 23)] = $urandom();
            pool_size = $urandom_range(4, 24);
            case ($urandom_range(0, 2))
                0:
                begin
                    insert_weight = 60;
                    remove_weight = 15;
                end
                1:
                begin
                    insert_weight = 15;
                    remove_weight = 60;
                end
                default:
                begin
                    insert_weight = 35;
                    remove_weight = 35;
                end
            endcase
            phase_len = $urandom_range(20, 80);
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++)
            begin
                sender_steady = (sent >= 250 && sent < 380);
                pick = $urandom_range(0, 99);
                if (pick < insert_weight)
                    op = MODE_INSERT;
                else if (pick < insert_weight + remove_weight)
                    op = MODE_REMOVE;
                else if (pick < 96)
                    op = MODE_QUERY;
                else
                    op = MODE_SPARE;
                if ($urandom_range(0, 9) == 0)
                    operand = $urandom();
                else
                    operand = value_pool[$urandom_range(0, pool_size - 1)];
                send_request(op, operand);
                sent++;
            end
            if ($urandom_range(0, 2) == 0)
                drain_results();
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_bounded_set_store passed");
        else
            $display("tb_bounded_set_store failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(5_000_000);
        $display("tb_bounded_set_store failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/bss_pkg.sv
rtl/core/bss_mem.sv
rtl/core/bss_seq.sv
rtl/core/bounded_set_store.sv
rtl/core/bss_checker.sv
dv/bss_result_checker.sv
dv/tb_bounded_set_store.sv
